// ===== sv/dmfm_pkg.sv =====
// ----------------------------------------------------------------------------
// dmfm_pkg
// Shared types and constants for the dew margin frame monitor.
// ----------------------------------------------------------------------------
package dmfm_pkg;

	localparam int MARGIN_W = 16;
	localparam int PIXEL_W  = 16;
	localparam int THRESH_W = 11;
	localparam int COUNT_W  = 32;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [MARGIN_W-1:0] LOW_MARGIN_INIT = 16'sd32767;
	localparam logic signed [THRESH_W-1:0] DANGER_INIT     = 11'sd100;
	localparam logic signed [THRESH_W-1:0] WARNING_INIT    = 11'sd300;

	typedef enum logic [1:0] {
		REQ_POINT  = 2'd0,
		REQ_EMPTY  = 2'd1,
		REQ_CLEAR  = 2'd2,
		REQ_UNUSED = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		LVL_OFF     = 2'd0,
		LVL_CLEAR   = 2'd1,
		LVL_WARNING = 2'd2,
		LVL_DANGER  = 2'd3
	} level_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DANGER  = 2'd0,
		CFG_WARNING = 2'd1,
		CFG_ENABLE  = 2'd2,
		CFG_NONE    = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] RISK_DANGER = 2'd2;

endpackage

// ===== sv/dew_margin_frame_monitor_core.sv =====
// ----------------------------------------------------------------------------
// dew_margin_frame_monitor_core
// Frame alarm classification and session statistics over a point stream.
// ----------------------------------------------------------------------------
// Output: a frame-end word shows its result in the cycle after it is accepted.
// Throughput: one word per cycle; the only hold-off is a result register
// that is full and stalled downstream.
// Reset: thresholds go to 100 and 300, alarm enabled, statistics cleared,
// result register empty.
module dew_margin_frame_monitor_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [dmfm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dmfm_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             req_type,
	input  logic signed [dmfm_pkg::MARGIN_W-1:0]   margin,
	input  logic [dmfm_pkg::PIXEL_W-1:0]           pixel,
	input  logic [1:0]                             risk,
	input  logic                                   last_point,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [1:0]                             alarm_level,
	output logic [dmfm_pkg::COUNT_W-1:0]           frames_seen,
	output logic [dmfm_pkg::COUNT_W-1:0]           danger_total,
	output logic signed [dmfm_pkg::MARGIN_W-1:0]   lowest_margin,
	output logic [dmfm_pkg::PIXEL_W-1:0]           coldest_index
);

	logic signed [dmfm_pkg::THRESH_W-1:0] danger_q;
	logic signed [dmfm_pkg::THRESH_W-1:0] warning_q;
	logic                                 enable_q;

	logic                                 frame_danger_q;
	logic                                 frame_warning_q;
	logic signed [dmfm_pkg::MARGIN_W-1:0] low_margin_q;
	logic [dmfm_pkg::PIXEL_W-1:0]         cold_pixel_q;
	logic [dmfm_pkg::COUNT_W-1:0]         danger_cnt_q;
	logic [dmfm_pkg::COUNT_W-1:0]         frame_cnt_q;

	logic                                 accept;
	logic                                 is_point;
	logic                                 emit;
	logic                                 new_low;
	logic                                 pt_danger;
	logic                                 pt_warning;
	logic                                 danger_nx;
	logic                                 warning_nx;
	logic signed [dmfm_pkg::MARGIN_W-1:0] low_nx;
	logic [dmfm_pkg::PIXEL_W-1:0]         pixel_nx;
	logic [dmfm_pkg::COUNT_W-1:0]         danger_cnt_nx;
	logic [dmfm_pkg::COUNT_W-1:0]         frame_cnt_nx;
	dmfm_pkg::level_t                     level_nx;

	function automatic logic signed [dmfm_pkg::MARGIN_W-1:0] MARGIN_W_EXT(
		input logic signed [dmfm_pkg::THRESH_W-1:0] t
	);
		return dmfm_pkg::MARGIN_W'(t);
	endfunction

	// hold input while a finished result waits downstream
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_point = (req_type == dmfm_pkg::REQ_POINT);
	assign emit     = (is_point && last_point) || (req_type == dmfm_pkg::REQ_EMPTY);

	always_comb begin
		new_low    = margin < low_margin_q;
		pt_danger  = margin <= MARGIN_W_EXT(danger_q);
		pt_warning = !pt_danger && (margin <= MARGIN_W_EXT(warning_q));

		low_nx        = low_margin_q;
		pixel_nx      = cold_pixel_q;
		danger_cnt_nx = danger_cnt_q;
		danger_nx     = frame_danger_q;
		warning_nx    = frame_warning_q;
		if (is_point) begin
			if (new_low) begin
				low_nx   = margin;
				pixel_nx = pixel;
			end
			if (risk == dmfm_pkg::RISK_DANGER) begin
				danger_cnt_nx = danger_cnt_q + 32'd1;
			end
			danger_nx  = frame_danger_q | pt_danger;
			warning_nx = frame_warning_q | pt_warning;
		end
		frame_cnt_nx = frame_cnt_q + 32'd1;

		priority if (!enable_q) begin
			level_nx = dmfm_pkg::LVL_OFF;
		end else if (danger_nx) begin
			level_nx = dmfm_pkg::LVL_DANGER;
		end else if (warning_nx) begin
			level_nx = dmfm_pkg::LVL_WARNING;
		end else begin
			level_nx = dmfm_pkg::LVL_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			danger_q  <= dmfm_pkg::DANGER_INIT;
			warning_q <= dmfm_pkg::WARNING_INIT;
			enable_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (dmfm_pkg::cfg_idx_t'(cfg_index))
				dmfm_pkg::CFG_DANGER:  danger_q  <= cfg_data;
				dmfm_pkg::CFG_WARNING: warning_q <= cfg_data;
				dmfm_pkg::CFG_ENABLE:  enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_danger_q  <= 1'b0;
			frame_warning_q <= 1'b0;
			low_margin_q    <= dmfm_pkg::LOW_MARGIN_INIT;
			cold_pixel_q    <= '0;
			danger_cnt_q    <= '0;
			frame_cnt_q     <= '0;
		end else if (accept) begin
			unique case (dmfm_pkg::req_t'(req_type))
				dmfm_pkg::REQ_POINT, dmfm_pkg::REQ_EMPTY: begin
					low_margin_q    <= low_nx;
					cold_pixel_q    <= pixel_nx;
					danger_cnt_q    <= danger_cnt_nx;
					// drop frame flags once the frame is reported
					frame_danger_q  <= danger_nx && !emit;
					frame_warning_q <= warning_nx && !emit;
					if (emit) begin
						frame_cnt_q <= frame_cnt_nx;
					end
				end
				dmfm_pkg::REQ_CLEAR: begin
					frame_danger_q  <= 1'b0;
					frame_warning_q <= 1'b0;
					low_margin_q    <= dmfm_pkg::LOW_MARGIN_INIT;
					cold_pixel_q    <= '0;
					danger_cnt_q    <= '0;
					frame_cnt_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept && emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			alarm_level   <= level_nx;
			frames_seen   <= frame_cnt_nx;
			danger_total  <= danger_cnt_nx;
			lowest_margin <= low_nx;
			coldest_index <= pixel_nx;
		end
	end

	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == dmfm_pkg::REQ_CLEAR |=>
			frame_cnt_q == '0 && danger_cnt_q == '0 &&
			low_margin_q == dmfm_pkg::LOW_MARGIN_INIT && !frame_danger_q)
		else $error("session clear did not reset statistics");

	a_emit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> out_valid && frames_seen == frame_cnt_q &&
			danger_total == danger_cnt_q && lowest_margin == low_margin_q)
		else $error("result does not match session statistics");

	a_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> !frame_danger_q && !frame_warning_q)
		else $error("frame flags survived frame end");

	a_disabled_off: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit && !enable_q |=> alarm_level == dmfm_pkg::LVL_OFF)
		else $error("alarm level set while disabled");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dew margin frame monitor core. A short table
// of directed words covers the threshold edges, the margin extremes, empty
// frames, session clears and ignored request codes. Random framed traffic
// follows under three settings of the thresholds. Every word that goes in
// updates a behavioral copy of the monitor, and each frame report that
// comes out is checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200_000;
	localparam int HOLD_CYCLES  = 300;
	localparam int WORDS_PER_PHASE = 500;

	typedef struct packed {
		dmfm_pkg::req_t req;
		logic [15:0]    margin;
		logic [15:0]    pixel;
		logic [1:0]     risk;
		logic           last;
	} point_t;

	typedef struct packed {
		dmfm_pkg::level_t level;
		logic [31:0]      frames;
		logic [31:0]      danger;
		logic [15:0]      lowest;
		logic [15:0]      coldest;
	} report_t;

	typedef struct packed {
		bit                 is_cfg;
		dmfm_pkg::cfg_idx_t reg_idx;
		logic [10:0]        reg_val;
		point_t             word;
		bit                 typed;
		report_t            want;
	} script_row_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [1:0]  cfg_index  = '0;
	logic [10:0] cfg_data   = '0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type   = '0;
	logic [15:0] margin     = '0;
	logic [15:0] pixel      = '0;
	logic [1:0]  risk       = '0;
	logic        last_point = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  alarm_level;
	logic [31:0] frames_seen;
	logic [31:0] danger_total;
	logic [15:0] lowest_margin;
	logic [15:0] coldest_index;

	dew_margin_frame_monitor_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .margin(margin), .pixel(pixel), .risk(risk),
		.last_point(last_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.alarm_level(alarm_level), .frames_seen(frames_seen),
		.danger_total(danger_total), .lowest_margin(lowest_margin),
		.coldest_index(coldest_index)
	);

	// behavioral copy of the monitor
	logic signed [10:0] p_danger_thr;
	logic signed [10:0] p_warn_thr;
	logic               p_enable;
	logic               p_frame_danger;
	logic               p_frame_warning;
	logic [15:0]        p_low;
	logic [15:0]        p_cold;
	logic [31:0]        p_risk_count;
	logic [31:0]        p_frame_count;

	report_t     frame_reports[$];
	script_row_t script[$];
	int          mismatch_count = 0;
	int          send_gap_pct   = 0;
	int          recv_stall_pct = 0;
	int          cycle_count    = 0;
	bit          start_hold     = 1'b0;
	logic        hold_results   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	function automatic report_t close_frame();
		report_t r;
		p_frame_count = p_frame_count + 32'd1;
		if (!p_enable)
			r.level = dmfm_pkg::LVL_OFF;
		else if (p_frame_danger)
			r.level = dmfm_pkg::LVL_DANGER;
		else if (p_frame_warning)
			r.level = dmfm_pkg::LVL_WARNING;
		else
			r.level = dmfm_pkg::LVL_CLEAR;
		r.frames  = p_frame_count;
		r.danger  = p_risk_count;
		r.lowest  = p_low;
		r.coldest = p_cold;
		p_frame_danger  = 1'b0;
		p_frame_warning = 1'b0;
		return r;
	endfunction

	function automatic void clear_stats();
		p_frame_danger  = 1'b0;
		p_frame_warning = 1'b0;
		p_low           = dmfm_pkg::LOW_MARGIN_INIT;
		p_cold          = '0;
		p_risk_count    = '0;
		p_frame_count   = '0;
	endfunction

	task automatic advance_monitor(input point_t w, output bit emits, output report_t r);
		emits = 1'b0;
		r = '0;
		case (w.req)
			dmfm_pkg::REQ_POINT: begin
				if ($signed(w.margin) < $signed(p_low)) begin
					p_low  = w.margin;
					p_cold = w.pixel;
				end
				if (w.risk == dmfm_pkg::RISK_DANGER)
					p_risk_count = p_risk_count + 32'd1;
				if ($signed(w.margin) <= p_danger_thr)
					p_frame_danger = 1'b1;
				else if ($signed(w.margin) <= p_warn_thr)
					p_frame_warning = 1'b1;
				if (w.last) begin
					r = close_frame();
					emits = 1'b1;
				end
			end
			dmfm_pkg::REQ_EMPTY: begin
				r = close_frame();
				emits = 1'b1;
			end
			dmfm_pkg::REQ_CLEAR: clear_stats();
			default: ;
		endcase
	endtask

	// results are taken at the next rising edge when valid and not stalled
	always @(negedge clk) begin
		report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_reports.size() == 0) begin
				flag_error($sformatf("unexpected report lvl=%0d frames=%0d",
					alarm_level, frames_seen));
			end else begin
				want = frame_reports.pop_front();
				if (alarm_level !== want.level || frames_seen !== want.frames ||
				    danger_total !== want.danger || lowest_margin !== want.lowest ||
				    coldest_index !== want.coldest)
					flag_error($sformatf({"report exp lvl=%0d fr=%0d dg=%0d lo=%0d px=%0d",
						" got lvl=%0d fr=%0d dg=%0d lo=%0d px=%0d"},
						want.level, want.frames, want.danger, $signed(want.lowest),
						want.coldest, alarm_level, frames_seen, danger_total,
						$signed(lowest_margin), coldest_index));
			end
		end
	end

	always @(posedge clk)
		out_stall <= hold_results | ($urandom_range(0, 99) < recv_stall_pct);

	// one long downstream hold so that the result register fills and backs up
	initial begin
		wait (start_hold);
		@(posedge clk);
		hold_results <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (frame_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input dmfm_pkg::cfg_idx_t idx, input logic [10:0] val);
		drain_reports();
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dmfm_pkg::CFG_DANGER:  p_danger_thr = val;
			dmfm_pkg::CFG_WARNING: p_warn_thr   = val;
			dmfm_pkg::CFG_ENABLE:  p_enable     = val[0];
			default: ;
		endcase
	endtask

	task automatic offer_word(input point_t w, input bit typed, input report_t want);
		bit      taken;
		bit      emits;
		report_t got;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= w.req;
		margin     <= w.margin;
		pixel      <= w.pixel;
		risk       <= w.risk;
		last_point <= w.last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		advance_monitor(w, emits, got);
		if (emits)
			frame_reports.push_back(typed ? want : got);
	endtask

	function automatic void add_word(input dmfm_pkg::req_t req, input int m, input int px,
			input int rk, input int last, input int typed = 0,
			input dmfm_pkg::level_t lv = dmfm_pkg::LVL_OFF,
			input int fr = 0, input int dg = 0, input int lo = 0, input int co = 0);
		script_row_t row;
		row = '0;
		row.word.req    = req;
		row.word.margin = m[15:0];
		row.word.pixel  = px[15:0];
		row.word.risk   = rk[1:0];
		row.word.last   = last[0];
		row.typed       = typed[0];
		row.want.level  = lv;
		row.want.frames = fr;
		row.want.danger = dg;
		row.want.lowest = lo[15:0];
		row.want.coldest = co[15:0];
		script.push_back(row);
	endfunction

	function automatic void add_cfg(input dmfm_pkg::cfg_idx_t idx, input int val);
		script_row_t row;
		row = '0;
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val[10:0];
		script.push_back(row);
	endfunction

	function automatic point_t random_word();
		point_t w;
		int     pick;
		int     m;
		pick = $urandom_range(0, 99);
		if (pick < 84)
			w.req = dmfm_pkg::REQ_POINT;
		else if (pick < 92)
			w.req = dmfm_pkg::REQ_EMPTY;
		else if (pick < 96)
			w.req = dmfm_pkg::REQ_CLEAR;
		else
			w.req = dmfm_pkg::REQ_UNUSED;
		// keep most margins near the thresholds
		if ($urandom_range(0, 3) != 0) begin
			m = $urandom_range(0, 1900) - 700;
			w.margin = m[15:0];
		end else begin
			w.margin = 16'($urandom_range(0, 65535));
		end
		w.pixel = 16'($urandom_range(0, 65535));
		w.risk  = 2'($urandom_range(0, 3));
		w.last  = ($urandom_range(0, 7) == 0);
		return w;
	endfunction

	function automatic logic [10:0] random_thr();
		int v;
		v = $urandom_range(0, 1500) - 500;
		return v[10:0];
	endfunction

	initial begin
		report_t none;
		none = '0;
		p_danger_thr = dmfm_pkg::DANGER_INIT;
		p_warn_thr   = dmfm_pkg::WARNING_INIT;
		p_enable     = 1'b1;
		clear_stats();

		// reset state, margin extremes, clear, threshold edges
		add_word(dmfm_pkg::REQ_EMPTY, 0, 0, 0, 0, 1, dmfm_pkg::LVL_CLEAR, 1, 0, 32767, 0);
		add_word(dmfm_pkg::REQ_POINT, -32768, 'hFFFF, 2, 1, 1, dmfm_pkg::LVL_DANGER,
			2, 1, -32768, 'hFFFF);
		add_word(dmfm_pkg::REQ_POINT, 32767, 0, 0, 1, 1, dmfm_pkg::LVL_CLEAR,
			3, 1, -32768, 'hFFFF);
		add_word(dmfm_pkg::REQ_CLEAR, 5, 7, 2, 1);
		add_word(dmfm_pkg::REQ_EMPTY, 0, 0, 0, 0, 1, dmfm_pkg::LVL_CLEAR, 1, 0, 32767, 0);
		add_word(dmfm_pkg::REQ_POINT, 300, 'h1234, 3, 1, 1, dmfm_pkg::LVL_WARNING,
			2, 0, 300, 'h1234);
		add_word(dmfm_pkg::REQ_POINT, 101, 'h2222, 2, 0);
		add_word(dmfm_pkg::REQ_POINT, 100, 'hABCD, 1, 0);
		add_word(dmfm_pkg::REQ_UNUSED, -5, 'h0F0F, 2, 1);
		add_word(dmfm_pkg::REQ_EMPTY, 0, 0, 0, 0);
		add_word(dmfm_pkg::REQ_POINT, 100, 'h5555, 0, 1);
		add_word(dmfm_pkg::REQ_POINT, 301, 'h0001, 2, 1);
		add_cfg(dmfm_pkg::CFG_ENABLE, 0);
		add_word(dmfm_pkg::REQ_POINT, -1, 'h8000, 2, 1);
		add_word(dmfm_pkg::REQ_EMPTY, 0, 0, 0, 0);
		add_cfg(dmfm_pkg::CFG_NONE, 'h7FF);
		add_cfg(dmfm_pkg::CFG_DANGER, -500);
		add_cfg(dmfm_pkg::CFG_WARNING, 1000);
		add_cfg(dmfm_pkg::CFG_ENABLE, 1);
		add_word(dmfm_pkg::REQ_POINT, -500, 'h00FF, 0, 1);
		add_word(dmfm_pkg::REQ_POINT, -499, 'hFF00, 2, 1);
		add_word(dmfm_pkg::REQ_POINT, 1000, 'h0F0F, 1, 1);
		add_word(dmfm_pkg::REQ_POINT, 1001, 'hF0F0, 3, 1);
		add_cfg(dmfm_pkg::CFG_DANGER, 1000);
		add_cfg(dmfm_pkg::CFG_WARNING, -500);
		add_word(dmfm_pkg::REQ_POINT, 1000, 'h7FFF, 2, 1);
		add_word(dmfm_pkg::REQ_POINT, 1001, 'h3C3C, 0, 1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				offer_word(script[i].word, script[i].typed, script[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_reg(dmfm_pkg::CFG_DANGER, random_thr());
					write_reg(dmfm_pkg::CFG_WARNING, random_thr());
					write_reg(dmfm_pkg::CFG_ENABLE, 11'd1);
					send_gap_pct   = 9;
					recv_stall_pct = 79;
				end
				1: begin
					write_reg(dmfm_pkg::CFG_DANGER, 11'd1000);
					write_reg(dmfm_pkg::CFG_WARNING, 11'(-500));
					write_reg(dmfm_pkg::CFG_ENABLE, 11'd1);
					send_gap_pct   = 79;
					recv_stall_pct = 9;
				end
				default: begin
					write_reg(dmfm_pkg::CFG_DANGER, 11'(-500));
					write_reg(dmfm_pkg::CFG_WARNING, random_thr());
					write_reg(dmfm_pkg::CFG_ENABLE, {10'd0, $urandom_range(0, 4) != 0});
					send_gap_pct   = 0;
					recv_stall_pct = 0;
					start_hold     = 1'b1;
				end
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// let the pipe run dry once mid-stream
				if (phase == 0 && n == WORDS_PER_PHASE / 2) begin
					drain_reports();
					@(posedge clk);
				end
				offer_word(random_word(), 1'b0, none);
			end
		end

		drain_reports();
		repeat (10) @(posedge clk);
		mismatch_count += frame_reports.size();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
